// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/sntp_pkg.sv -----
// types and constants of the sntp reply checker
package sntp_pkg;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] rtt_ms;
  } in_beat_t;

  typedef struct packed {
    logic [42:0] time_ms;
    logic [2:0]  status;
  } out_beat_t;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_BAD_SENDER  = 3'd1;
  localparam logic [2:0] STATUS_BAD_PORT    = 3'd2;
  localparam logic [2:0] STATUS_BAD_LENGTH  = 3'd3;
  localparam logic [2:0] STATUS_BAD_MODE    = 3'd4;
  localparam logic [2:0] STATUS_STRATUM_0   = 3'd5;

  localparam logic [31:0] NTP_EPOCH_OFFSET  = 32'd2208988800;
  localparam logic [15:0] NTP_PORT          = 16'd123;
  localparam logic [5:0]  NTP_LENGTH        = 6'd48;
  localparam logic [2:0]  NTP_MODE_SERVER   = 3'd4;
  localparam logic [5:0]  STAMP_FIRST       = 6'd40;
  localparam logic [5:0]  COUNT_MAX         = 6'd63;
  localparam logic [9:0]  MS_PER_SEC        = 10'd1000;

endpackage

// ----- sv/sntp_response_timestamp_parser.sv -----
// sntp reply checker: validates a udp ntp reply and converts its transmit stamp to unix ms
// One payload byte is taken per cycle while in_ready is high, with no gaps needed; header
// fields and the transmit timestamp are captured as the bytes stream by. The beat marked
// last_byte produces one result: the s1 registers take the checks and the epoch-shifted
// seconds, then the output register takes the two seconds/fraction by 1000 multiplies and
// the final add. Results stall in the output register under backpressure; bytes keep
// being accepted until a second result is waiting behind the stalled one. server_address
// is written through cfg_we/cfg_wdata.
module sntp_response_timestamp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sntp_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sntp_pkg::out_beat_t  out_data
);

  logic [31:0] server_r;
  logic [5:0]  count_r, count_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  stratum_r, stratum_nxt;
  logic [63:0] stamp_r, stamp_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic [2:0]  s1_status_r, status_nxt;
  logic [31:0] s1_secs_r;
  logic [31:0] s1_frac_r;
  logic [14:0] s1_half_r;

  logic        out_valid_r, out_valid_nxt;
  sntp_pkg::out_beat_t out_r;

  logic        accept, last_accept, s1_adv;
  logic [41:0] secs_ms, frac_ms;
  logic [42:0] time_sum;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready    = rst_n && (!s1_valid_r || s1_adv);
  assign accept      = in_valid && in_ready;
  assign last_accept = accept && in_data.last_byte;

  // frame state update for the current beat
  always_comb begin
    count_nxt   = (count_r < sntp_pkg::COUNT_MAX) ? count_r + 6'd1 : count_r;
    mode_nxt    = (count_r == 6'd0) ? in_data.payload_byte[2:0] : mode_r;
    stratum_nxt = (count_r == 6'd1) ? in_data.payload_byte : stratum_r;
    stamp_nxt   = stamp_r;
    if (count_r[5:3] == sntp_pkg::STAMP_FIRST[5:3]) begin
      for (int k = 0; k < 8; k++) begin
        if (count_r[2:0] == 3'(k)) begin
          stamp_nxt[63 - 8*k -: 8] = stamp_r[63 - 8*k -: 8] | in_data.payload_byte;
        end
      end
    end
  end

  // first failing check wins
  always_comb begin
    if (in_data.source_address != server_r) begin
      status_nxt = sntp_pkg::STATUS_BAD_SENDER;
    end else if (in_data.source_port != sntp_pkg::NTP_PORT) begin
      status_nxt = sntp_pkg::STATUS_BAD_PORT;
    end else if (count_nxt != sntp_pkg::NTP_LENGTH) begin
      status_nxt = sntp_pkg::STATUS_BAD_LENGTH;
    end else if (mode_nxt != sntp_pkg::NTP_MODE_SERVER) begin
      status_nxt = sntp_pkg::STATUS_BAD_MODE;
    end else if (stratum_nxt == 8'd0) begin
      status_nxt = sntp_pkg::STATUS_STRATUM_0;
    end else begin
      status_nxt = sntp_pkg::STATUS_OK;
    end
  end

  always_comb begin
    s1_valid_nxt = last_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // result stage arithmetic
  assign secs_ms  = 42'(s1_secs_r) * 42'(sntp_pkg::MS_PER_SEC);
  assign frac_ms  = 42'(s1_frac_r) * 42'(sntp_pkg::MS_PER_SEC);
  assign time_sum = 43'(secs_ms) + 43'(frac_ms[41:32]) + 43'(s1_half_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_r    <= '0;
      count_r     <= '0;
      mode_r      <= '0;
      stratum_r   <= '0;
      stamp_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        server_r <= cfg_wdata;
      end
      if (accept) begin
        if (in_data.last_byte) begin
          count_r   <= '0;
          mode_r    <= '0;
          stratum_r <= '0;
          stamp_r   <= '0;
        end else begin
          count_r   <= count_nxt;
          mode_r    <= mode_nxt;
          stratum_r <= stratum_nxt;
          stamp_r   <= stamp_nxt;
        end
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (last_accept) begin
      s1_status_r <= status_nxt;
      if (status_nxt == sntp_pkg::STATUS_OK) begin
        s1_secs_r <= stamp_nxt[63:32] - sntp_pkg::NTP_EPOCH_OFFSET;
        s1_frac_r <= stamp_nxt[31:0];
        s1_half_r <= in_data.rtt_ms[15:1];
      end else begin
        s1_secs_r <= '0;
        s1_frac_r <= '0;
        s1_half_r <= '0;
      end
    end
    if (s1_adv) begin
      out_r.time_ms <= time_sum;
      out_r.status  <= s1_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/sntp_chk.sv -----
// port-level checker for the sntp reply checker, bound to sntp_response_timestamp_parser
`include "assert_macros.svh"

module sntp_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input sntp_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input sntp_pkg::out_beat_t out_data
);

  // stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // rejected replies carry no time
  `ASSERT_SAME(a_zero_time, clk, rst_n, out_valid && out_data.status != sntp_pkg::STATUS_OK, out_data.time_ms == 43'd0)

  // only defined status codes
  `ASSERT_SAME(a_status_range, clk, rst_n, out_valid, out_data.status <= sntp_pkg::STATUS_STRATUM_0)

  // a new result follows an accepted last beat, by way of the s1 register
  `ASSERT_SAME(a_result_src, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_data.last_byte, 2))

endmodule

bind sntp_response_timestamp_parser sntp_chk u_sntp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
